/* hdl/slab_pkg.sv */
// Shared Q30 number format and sRGB linearisation table for the sRGB to CIELAB unit.
`timescale 1ns / 1ps
`default_nettype none
package slab_pkg;

  localparam int QB = 30;           // fraction bits of internal values
  localparam int QW = QB + 1;       // holds 0 up to and including 1.0
  localparam logic [QW-1:0] QONE = QW'(1) << QB;
  localparam int DIV_LAT = 3;       // register stages of a constant divider

  typedef logic [QW-1:0] qval_t;
  typedef qval_t lin_rom_t [256];

  // Rounded Q30 product.
  function automatic longint unsigned mul_q(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << (QB - 1))) >> QB;
  endfunction

  // Largest Q30 r below 1.0 with r^5 <= w, each power built from rounded products; 1.0 when w is at least 1.0.
  function automatic longint unsigned root5_q(longint unsigned w);
    longint unsigned r;
    longint unsigned cand;
    longint unsigned p;
    r = 64'd0;
    if (w >= (64'd1 << QB)) begin
      return 64'd1 << QB;
    end
    for (int k = QB - 1; k >= 0; k--) begin
      cand = r | (64'd1 << k);
      p = cand;
      for (int n = 1; n < 5; n++) begin
        p = mul_q(p, cand);
      end
      if (p <= w) begin
        r = cand;
      end
    end
    return r;
  endfunction

  // sRGB code to linear light in Q30.
  function automatic longint unsigned lin_value(longint unsigned code);
    longint unsigned u;
    longint unsigned w;
    if (code <= 64'd10) begin
      return (code * 64'd5 * (64'd1 << QB) + 64'd8236) / 64'd16473;
    end
    u = (((64'd1000 * code + 64'd14025) << QB) + 64'd134512) / 64'd269025;
    w = mul_q(u, u);
    return mul_q(w, root5_q(w));
  endfunction

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t rom;
    for (int c = 0; c < 256; c++) begin
      rom[c] = QW'(lin_value(64'(c)));
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage
`default_nettype wire

/* hdl/slab_div.sv */
// Pipelined divider by a constant: reciprocal multiplication over three register stages.
`timescale 1ns / 1ps
`default_nettype none
module slab_div
  import slab_pkg::*;
#(
  parameter int DIVIDEND_W = 54,
  parameter int QUOTIENT_W = 31,
  parameter longint unsigned DIVISOR = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  valid,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic                  quotient_valid,
  output logic [QUOTIENT_W-1:0] quotient
);

  localparam int DIVISOR_W = $clog2(DIVISOR + 1);
  // error of the rounded-up reciprocal times any dividend stays below 2^SHIFT
  localparam int SHIFT = DIVIDEND_W + DIVISOR_W;
  localparam int MW    = DIVIDEND_W + 2;
  localparam int NL    = DIVIDEND_W / 2;
  localparam int NH    = DIVIDEND_W - NL;
  localparam int ML    = MW / 2;
  localparam int MH    = MW - ML;
  localparam int PRW   = DIVIDEND_W + MW;

  function automatic logic [MW-1:0] reciprocal();
    logic [127:0] scaled;
    scaled = (128'd1 << SHIFT) + 128'(DIVISOR) - 128'd1;
    return MW'(scaled / 128'(DIVISOR));
  endfunction

  localparam logic [MW-1:0] MULT = reciprocal();
  localparam logic [ML-1:0] M_LO = MULT[ML-1:0];
  localparam logic [MH-1:0] M_HI = MULT[MW-1:ML];

  logic [DIV_LAT-1:0] vld;
  logic [NL+ML-1:0]   pp_ll;
  logic [NL+MH-1:0]   pp_lh;
  logic [NH+ML-1:0]   pp_hl;
  logic [NH+MH-1:0]   pp_hh;
  logic [PRW-1:0]     part_lo;
  logic [PRW-1:0]     part_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_LAT-2:0], valid};
    end
    if (en) begin
      pp_ll    <= (NL+ML)'(dividend[NL-1:0]) * (NL+ML)'(M_LO);
      pp_lh    <= (NL+MH)'(dividend[NL-1:0]) * (NL+MH)'(M_HI);
      pp_hl    <= (NH+ML)'(dividend[DIVIDEND_W-1:NL]) * (NH+ML)'(M_LO);
      pp_hh    <= (NH+MH)'(dividend[DIVIDEND_W-1:NL]) * (NH+MH)'(M_HI);
      part_lo  <= PRW'(pp_ll) + (PRW'(pp_lh) << ML);
      part_hi  <= (PRW'(pp_hl) << NL) + (PRW'(pp_hh) << (NL + ML));
      quotient <= QUOTIENT_W'((part_lo + part_hi) >> SHIFT);
    end
  end

  assign quotient_valid = vld[DIV_LAT-1];

endmodule
`default_nettype wire

/* hdl/slab_curve.sv */
// CIELAB companding curve: pipelined bitwise cube root with a linear segment near zero.
`timescale 1ns / 1ps
`default_nettype none
module slab_curve
  import slab_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  valid,
  input  qval_t t,
  output logic  f_valid,
  output qval_t f
);

  localparam longint unsigned LIN_LIMIT  = (64'd8856 << QB) / 64'd1000000;
  localparam longint unsigned LIN_OFFSET = ((64'd4 << QB) + 64'd14) / 64'd29;
  localparam longint unsigned LIN_MAX    = LIN_LIMIT * 64'd7787 + 64'd500;
  localparam int LIN_W     = $clog2(LIN_LIMIT + 1);
  localparam int LD_W      = $clog2(LIN_MAX + 1);
  localparam int LQ_W      = $clog2(LIN_MAX / 64'd1000 + 1);
  localparam int ROOT_LAT  = 2 * QB;
  localparam int LIN_DELAY = ROOT_LAT - 1 - DIV_LAT;
  localparam int PW        = QW + QB;
  localparam logic [2*QB-1:0] HALF_SQ = (2*QB)'(1) << (QB - 1);
  localparam logic [PW-1:0]   HALF_P  = PW'(1) << (QB - 1);

  // root pipeline: A stages square the candidate, B stages cube and compare
  logic [QB-1:0]   a_r    [QB];
  logic [2*QB-1:0] a_rsq  [QB];
  logic [QB-1:0]   a_cand [QB];
  logic [2*QB-1:0] a_csq  [QB];
  logic [QW-1:0]   a_m    [QB];
  qval_t           a_t    [QB];
  logic            a_lin  [QB];
  logic            a_one  [QB];
  logic            a_vld  [QB];
  logic [QB-1:0]   b_r    [QB];
  logic [2*QB-1:0] b_rsq  [QB];
  qval_t           b_t    [QB];
  logic            b_lin  [QB];
  logic            b_one  [QB];
  logic            b_vld  [QB];

  logic [QB-1:0]   src_r   [QB];
  logic [2*QB-1:0] src_rsq [QB];
  qval_t           src_t   [QB];
  logic            src_lin [QB];
  logic            src_one [QB];
  logic            src_vld [QB];

  logic [QB-1:0]   a_cand_next [QB];
  logic [2*QB-1:0] a_csq_next  [QB];
  logic [QW-1:0]   a_m_next    [QB];
  logic            take        [QB];

  logic            is_lin;
  logic [LD_W-1:0] lin_num;
  logic            lin_num_vld;
  logic            lin_q_vld;
  logic [LQ_W-1:0] lin_q;
  logic [LQ_W-1:0] lin_dly     [LIN_DELAY];
  logic            lin_dly_vld [LIN_DELAY];

  assign is_lin = t <= QW'(LIN_LIMIT);

  always_comb begin
    src_r[0]   = '0;
    src_rsq[0] = '0;
    src_t[0]   = t;
    src_lin[0] = is_lin;
    src_one[0] = t >= QONE;
    src_vld[0] = valid;
    for (int j = 1; j < QB; j++) begin
      src_r[j]   = b_r[j-1];
      src_rsq[j] = b_rsq[j-1];
      src_t[j]   = b_t[j-1];
      src_lin[j] = b_lin[j-1];
      src_one[j] = b_one[j-1];
      src_vld[j] = b_vld[j-1];
    end
  end

  // (r + 2^k)^2 kept exact, so squaring the candidate is only an add
  always_comb begin
    logic [2*QB-1:0] csq;
    for (int j = 0; j < QB; j++) begin
      a_cand_next[j] = src_r[j] | (QB'(1) << (QB - 1 - j));
      csq = src_rsq[j] + ((2*QB)'(src_r[j]) << (QB - j))
            + ((2*QB)'(1) << (2 * (QB - 1 - j)));
      a_csq_next[j] = csq;
      a_m_next[j]   = QW'((csq + HALF_SQ) >> QB);
    end
  end

  always_comb begin
    logic [PW-1:0] prod;
    logic [QW:0]   cube;
    for (int j = 0; j < QB; j++) begin
      prod    = PW'(a_m[j]) * PW'(a_cand[j]);
      cube    = (QW+1)'((prod + HALF_P) >> QB);
      take[j] = cube <= {1'b0, a_t[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < QB; j++) begin
        a_vld[j] <= 1'b0;
        b_vld[j] <= 1'b0;
      end
    end else if (en) begin
      a_vld <= src_vld;
      b_vld <= a_vld;
    end
    if (en) begin
      a_r    <= src_r;
      a_rsq  <= src_rsq;
      a_t    <= src_t;
      a_lin  <= src_lin;
      a_one  <= src_one;
      a_cand <= a_cand_next;
      a_csq  <= a_csq_next;
      a_m    <= a_m_next;
      b_t    <= a_t;
      b_lin  <= a_lin;
      b_one  <= a_one;
      for (int j = 0; j < QB; j++) begin
        b_r[j]   <= take[j] ? a_cand[j] : a_r[j];
        b_rsq[j] <= take[j] ? a_csq[j] : a_rsq[j];
      end
    end
  end

  // linear segment, only meaningful when the value is small
  always_ff @(posedge clk) begin
    if (rst) begin
      lin_num_vld <= 1'b0;
    end else if (en) begin
      lin_num_vld <= valid;
    end
    if (en) begin
      lin_num <= is_lin ? LD_W'(t[LIN_W-1:0]) * LD_W'(7787) + LD_W'(500) : LD_W'(500);
    end
  end

  slab_div #(
    .DIVIDEND_W (LD_W),
    .QUOTIENT_W (LQ_W),
    .DIVISOR    (64'd1000)
  ) u_lin_div (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .valid          (lin_num_vld),
    .dividend       (lin_num),
    .quotient_valid (lin_q_vld),
    .quotient       (lin_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LIN_DELAY; i++) begin
        lin_dly_vld[i] <= 1'b0;
      end
      f_valid <= 1'b0;
    end else if (en) begin
      lin_dly_vld[0] <= lin_q_vld;
      for (int i = 1; i < LIN_DELAY; i++) begin
        lin_dly_vld[i] <= lin_dly_vld[i-1];
      end
      f_valid <= b_vld[QB-1] && lin_dly_vld[LIN_DELAY-1];
    end
    if (en) begin
      lin_dly[0] <= lin_q;
      for (int i = 1; i < LIN_DELAY; i++) begin
        lin_dly[i] <= lin_dly[i-1];
      end
      if (b_one[QB-1]) begin
        f <= QONE;
      end else if (b_lin[QB-1]) begin
        f <= QW'(lin_dly[LIN_DELAY-1]) + QW'(LIN_OFFSET);
      end else begin
        f <= {1'b0, b_r[QB-1]};
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/srgb_to_cielab_unit.sv */
// Top level of the sRGB to CIELAB (D65) pixel converter.
`timescale 1ns / 1ps
`default_nettype none
// Converts one 8-bit sRGB pixel per clock to CIELAB with FRACTION_BITS fraction bits,
// rounded to nearest; a and b saturate at the 16-bit range. A pixel passes, from
// acceptance to its result, through table lookup, matrix products and sums, the
// reciprocal-multiply constant dividers that normalise X, Y and Z, the cube-root
// pipeline at two stages per root bit plus its output register, and the final
// scale, round and clamp. Every stage moves on a single advance enable, so a
// held result stalls the whole pipeline and pixel_ready falls only while lab_valid
// waits on lab_ready.
module srgb_to_cielab_unit
  import slab_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic               lab_valid,
  input  logic               lab_ready,
  output logic [14:0]        lightness,
  output logic signed [15:0] green_red_axis,
  output logic signed [15:0] blue_yellow_axis
);

  localparam int CW = 24;
  localparam int PW = CW + QW;
  localparam int DW = 54;
  localparam int VW = 42;
  localparam int OUT_SHIFT = QB - FRACTION_BITS;
  // rows X, Y, Z; columns r, g, b
  localparam logic [CW-1:0] COEF [9] = '{
    CW'(4124564), CW'(3575761), CW'(1804375),
    CW'(2126729), CW'(7151522), CW'(721750),
    CW'(193339),  CW'(1191920), CW'(9503041)
  };
  localparam logic [DW-1:0] HALF_X = DW'(4752350);
  localparam logic [DW-1:0] HALF_Y = DW'(5000000);
  localparam logic [DW-1:0] HALF_Z = DW'(5444150);
  localparam logic signed [VW-1:0] K116    = VW'(116);
  localparam logic signed [VW-1:0] K500    = VW'(500);
  localparam logic signed [VW-1:0] K200    = VW'(200);
  localparam logic signed [VW-1:0] L_BIAS  = VW'(16) << QB;
  localparam logic signed [VW-1:0] HALF_O  = VW'(1) << (OUT_SHIFT - 1);
  localparam logic signed [VW-1:0] SAT_MAX = VW'(32767);
  localparam logic signed [VW-1:0] SAT_MIN = -(VW'(32768));

  logic adv;
  logic v1, v2, v3, vo1;
  qval_t lin [3];
  logic [PW-1:0] prod [9];
  logic [DW-1:0] sx, sy, sz;
  logic vqx, vqy, vqz;
  qval_t qx, qy, qz;
  logic fvx, fvy, fvz;
  qval_t fx, fy, fz;
  logic signed [VW-1:0] fx_s, fy_s, fz_s;
  logic signed [VW-1:0] vl, va, vb;
  logic signed [VW-1:0] rl, ra, rb;

  assign adv         = !lab_valid || lab_ready;
  assign pixel_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= pixel_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (adv) begin
      lin[0] <= LIN_ROM[red];
      lin[1] <= LIN_ROM[green];
      lin[2] <= LIN_ROM[blue];
      for (int i = 0; i < 9; i++) begin
        prod[i] <= PW'(COEF[i]) * PW'(lin[i % 3]);
      end
      sx <= DW'(prod[0] + prod[1] + prod[2] + PW'(HALF_X));
      sy <= DW'(prod[3] + prod[4] + prod[5] + PW'(HALF_Y));
      sz <= DW'(prod[6] + prod[7] + prod[8] + PW'(HALF_Z));
    end
  end

  slab_div #(.DIVIDEND_W(DW), .QUOTIENT_W(QW), .DIVISOR(64'd9504700)) u_div_x (
    .clk(clk), .rst(rst), .en(adv), .valid(v3), .dividend(sx),
    .quotient_valid(vqx), .quotient(qx)
  );
  slab_div #(.DIVIDEND_W(DW), .QUOTIENT_W(QW), .DIVISOR(64'd10000000)) u_div_y (
    .clk(clk), .rst(rst), .en(adv), .valid(v3), .dividend(sy),
    .quotient_valid(vqy), .quotient(qy)
  );
  slab_div #(.DIVIDEND_W(DW), .QUOTIENT_W(QW), .DIVISOR(64'd10888300)) u_div_z (
    .clk(clk), .rst(rst), .en(adv), .valid(v3), .dividend(sz),
    .quotient_valid(vqz), .quotient(qz)
  );

  slab_curve u_curve_x (
    .clk(clk), .rst(rst), .en(adv), .valid(vqx), .t(qx), .f_valid(fvx), .f(fx)
  );
  slab_curve u_curve_y (
    .clk(clk), .rst(rst), .en(adv), .valid(vqy), .t(qy), .f_valid(fvy), .f(fy)
  );
  slab_curve u_curve_z (
    .clk(clk), .rst(rst), .en(adv), .valid(vqz), .t(qz), .f_valid(fvz), .f(fz)
  );

  assign fx_s = signed'(VW'(fx));
  assign fy_s = signed'(VW'(fy));
  assign fz_s = signed'(VW'(fz));

  // arithmetic shift gives the floor of the biased quotient
  assign rl = (vl + HALF_O) >>> OUT_SHIFT;
  assign ra = (va + HALF_O) >>> OUT_SHIFT;
  assign rb = (vb + HALF_O) >>> OUT_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo1       <= 1'b0;
      lab_valid <= 1'b0;
    end else if (adv) begin
      vo1       <= fvx && fvy && fvz;
      lab_valid <= vo1;
    end
    if (adv) begin
      vl <= fy_s * K116 - L_BIAS;
      va <= (fx_s - fy_s) * K500;
      vb <= (fy_s - fz_s) * K200;
      if (rl < 0) begin
        lightness <= '0;
      end else if (rl > SAT_MAX) begin
        lightness <= 15'h7fff;
      end else begin
        lightness <= rl[14:0];
      end
      if (ra > SAT_MAX) begin
        green_red_axis <= 16'sh7fff;
      end else if (ra < SAT_MIN) begin
        green_red_axis <= -16'sh8000;
      end else begin
        green_red_axis <= ra[15:0];
      end
      if (rb > SAT_MAX) begin
        blue_yellow_axis <= 16'sh7fff;
      end else if (rb < SAT_MIN) begin
        blue_yellow_axis <= -16'sh8000;
      end else begin
        blue_yellow_axis <= rb[15:0];
      end
    end
  end

`ifndef SYNTHESIS
  // the three channel pipelines stay in lock step
  a_channels_aligned: assert property (@(posedge clk) disable iff (rst)
    (fvx == fvy) && (fvy == fvz))
    else $error("curve pipelines out of step");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> v1)
    else $error("accepted transaction missing from first stage");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |=> $stable(v3) && $stable(vo1) && $stable(vqy))
    else $error("pipeline moved during a stall");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    lab_valid && !lab_ready |=> lab_valid && $stable(lightness) &&
    $stable(green_red_axis) && $stable(blue_yellow_axis))
    else $error("waiting result changed");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb_srgb_to_cielab_unit.sv */
// Self-checking testbench for the sRGB to CIELAB pixel converter.
`timescale 1ns / 1ps
module tb_srgb_to_cielab_unit;
  localparam int FRAC = 8;
  localparam int OSH = 30 - FRAC;
  localparam longint unsigned ONE = 64'd1 << 30;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [14:0] l;
    logic [15:0] a;
    logic [15:0] b;
  } lab_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_ready;
  logic [7:0] red = '0, green = '0, blue = '0;
  logic lab_valid;
  logic lab_ready = 1'b0;
  logic [14:0] lightness;
  logic signed [15:0] green_red_axis, blue_yellow_axis;

  lab_t expected_lab[$];
  int mismatches = 0;
  int cycles = 0;
  bit hold_off = 0;
  bit lazy_sink = 0;
  longint unsigned gamma_table [256];

  srgb_to_cielab_unit #(.FRACTION_BITS(FRAC)) dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned qmul(longint unsigned x, longint unsigned y);
    return (x * y + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned qroot(longint unsigned w, int n);
    longint unsigned r, cand, p;
    r = 0;
    if (w >= ONE) return ONE;
    for (int k = 29; k >= 0; k--) begin
      cand = r | (64'd1 << k);
      p = cand;
      for (int i = 1; i < n; i++) p = qmul(p, cand);
      if (p <= w) r = cand;
    end
    return r;
  endfunction

  function automatic longint unsigned gamma_lin(longint unsigned c);
    longint unsigned u, w;
    if (c <= 10) return (c * 5 * ONE + 8236) / 16473;
    u = (((1000 * c + 14025) << 30) + 134512) / 269025;
    w = qmul(u, u);
    return qmul(w, qroot(w, 5));
  endfunction

  function automatic longint lab_f(longint unsigned t);
    if (t * 1000000 > 8856 * ONE) return longint'(qroot(t, 3));
    return longint'((t * 7787 + 500) / 1000 + (4 * ONE + 14) / 29);
  endfunction

  function automatic longint scale_round(longint v, longint lo, longint hi);
    longint o;
    o = (v + (longint'(1) << (OSH - 1))) >>> OSH;
    return o < lo ? lo : (o > hi ? hi : o);
  endfunction

  function automatic lab_t convert_pixel(logic [7:0] rc, logic [7:0] gc, logic [7:0] bc);
    longint unsigned r, g, b, x, y, z;
    longint fx, fy, fz;
    lab_t res;
    r = gamma_table[rc];
    g = gamma_table[gc];
    b = gamma_table[bc];
    x = (4124564 * r + 3575761 * g + 1804375 * b + 4752350) / 9504700;
    y = (2126729 * r + 7151522 * g + 721750 * b + 5000000) / 10000000;
    z = (193339 * r + 1191920 * g + 9503041 * b + 5444150) / 10888300;
    fx = lab_f(x);
    fy = lab_f(y);
    fz = lab_f(z);
    res.l = 15'(scale_round(116 * fy - 16 * longint'(ONE), 0, 32767));
    res.a = 16'(scale_round(500 * (fx - fy), -32768, 32767));
    res.b = 16'(scale_round(200 * (fy - fz), -32768, 32767));
    return res;
  endfunction

  // valid stays high after the transaction; pause() with a nonzero length or drain() drops it
  task automatic send_pixel(logic [7:0] rc, logic [7:0] gc, logic [7:0] bc);
    red <= rc;
    green <= gc;
    blue <= bc;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (!pixel_ready);
    expected_lab.push_back(convert_pixel(rc, gc, bc));
    @(negedge clk);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      pixel_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // bursts separated by random gaps
  task automatic send_random(int n, bit saturated);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        pause($urandom_range(0, 6));
        burst = $urandom_range(1, 20);
      end
      burst--;
      if (saturated)
        send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00, 8'($urandom),
                   $urandom_range(0, 1) ? 8'hff : 8'h00);
      else
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain();
    pixel_valid <= 1'b0;
    while (expected_lab.size() != 0) @(negedge clk);
  endtask

  task automatic test_extremes();
    logic [7:0] lv[6] = '{8'd0, 8'd10, 8'd11, 8'd128, 8'd254, 8'd255};
    for (int i = 0; i < 6; i++) send_pixel(lv[i], lv[i], lv[i]);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'haa, 8'h55, 8'haa);
    send_pixel(8'h55, 8'haa, 8'h55);
  endtask

  // sink held off long enough to fill the pipeline and stall the input
  task automatic test_backpressure();
    fork
      begin
        @(posedge clk);
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
    join_none
    send_random(150, 0);
    drain();
  endtask

  task automatic test_random();
    send_random(1000, 0);
    drain();
    send_random(300, 1);
    lazy_sink = 1;
    send_random(300, 0);
    lazy_sink = 0;
  endtask

  always @(negedge clk) begin
    if (rst || hold_off) lab_ready <= 1'b0;
    else if (lazy_sink) lab_ready <= ($urandom_range(0, 3) == 0);
    else lab_ready <= ($urandom_range(0, 3) != 0) || (cycles % 500 < 100);
  end

  always @(posedge clk) begin
    lab_t want;
    cycles <= cycles + 1;
    if (!rst && lab_valid && lab_ready) begin
      if (expected_lab.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction at cycle %0d", cycles);
      end else begin
        want = expected_lab.pop_front();
        if (want.l !== lightness || want.a !== green_red_axis ||
            want.b !== blue_yellow_axis) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp L=%0d a=%0d b=%0d got L=%0d a=%0d b=%0d",
                     want.l, $signed(want.a), $signed(want.b),
                     lightness, green_red_axis, blue_yellow_axis);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < 256; c++) gamma_table[c] = gamma_lin(c);
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    drain();
    test_backpressure();
    test_random();
    drain();
    repeat (120) @(negedge clk);
    if (mismatches == 0 && expected_lab.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
